[src/jst_pkg.sv]
// Shared types, character constants and small decode helpers for the JSON subset tokenizer.
// Depends on nothing; used by json_subset_tokenizer_core, the checker and the testbench.
package jst_pkg;

  // Parser position, one-hot coded.
  typedef enum logic [11:0] {
    M_TOP       = 12'b0000_0000_0001,
    M_VALUE     = 12'b0000_0000_0010,
    M_OBJ_FIRST = 12'b0000_0000_0100,
    M_KEY_NEXT  = 12'b0000_0000_1000,
    M_COLON     = 12'b0000_0001_0000,
    M_AFTER     = 12'b0000_0010_0000,
    M_STR       = 12'b0000_0100_0000,
    M_ESC       = 12'b0000_1000_0000,
    M_HEX       = 12'b0001_0000_0000,
    M_NSIGN     = 12'b0010_0000_0000,
    M_NDIG      = 12'b0100_0000_0000,
    M_END       = 12'b1000_0000_0000
  } mode_t;

  typedef enum logic [3:0] {
    EV_OPEN     = 4'd0,
    EV_CLOSE    = 4'd1,
    EV_KEY_BYTE = 4'd2,
    EV_KEY_END  = 4'd3,
    EV_STR_BYTE = 4'd4,
    EV_STR_END  = 4'd5,
    EV_INT      = 4'd6,
    EV_DONE     = 4'd7,
    EV_ERROR    = 4'd8
  } ev_kind_t;

  typedef enum logic [3:0] {
    ERR_NONE_END  = 4'd0,
    ERR_BAD_VALUE = 4'd1,
    ERR_EXPECTED  = 4'd2,
    ERR_COMMA     = 4'd3,
    ERR_ESCAPE    = 4'd4,
    ERR_HEX       = 4'd5,
    ERR_NUMBER    = 4'd6,
    ERR_FLOAT     = 4'd7,
    ERR_OVERFLOW  = 4'd8,
    ERR_TRAILING  = 4'd9,
    ERR_DEPTH     = 4'd10
  } err_code_t;

  // One result beat as it waits in the output queue.
  typedef struct packed {
    ev_kind_t         kind;
    logic [7:0]       data_byte;
    logic [63:0]      int_value;
    err_code_t        code;
    logic             last;
  } event_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [7:0] UTF_LEAD = 8'hC0;
  localparam logic [7:0] UTF_CONT = 8'h80;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
      return {1'b0, t[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      return {1'b0, t[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      return {1'b0, t[3:0]};
    end
    return 5'b1_0000;
  endfunction

  function automatic event_t mk_ev(input ev_kind_t k, input logic [7:0] d,
                                   input logic [63:0] v, input err_code_t c);
    event_t e;
    e.kind      = k;
    e.data_byte = d;
    e.int_value = v;
    e.code      = c;
    e.last      = 1'b0;
    return e;
  endfunction

endpackage

[src/json_subset_tokenizer_core.sv]
// A beat's results are registered into the queue at the edge that accepts the beat.
// Throughput: one input beat per cycle while out_tready stays high and each beat yields at most
// one result; a beat that yields two results (a unicode escape at or above 0x80, or an integer
// closed by a following close, end or error) holds the input while the three-entry queue drains.
// Reset (rst_n low, synchronous) returns the parser to its start state and empties the queue.
// Top level of the JSON subset tokenizer; depends on jst_pkg.
module json_subset_tokenizer_core #(
  parameter int MAX_DEPTH = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: tdata = data_in[7:0]; tuser = func (1 marks end of text).
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  // Result stream: tdata = data_byte[7:0], int_value[71:8], error_code[75:72], zero pad [79:76];
  // tuser = event_kind[3:0]; tlast = last_of_run.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,
  output logic [3:0]  out_tuser,
  output logic        out_tlast
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam logic [DW-1:0] MAX_D = DW'(MAX_DEPTH);
  // Largest magnitudes that still fit a signed 64-bit value.
  localparam logic [67:0] LIMIT_POS = {5'd0, {63{1'b1}}};
  localparam logic [67:0] LIMIT_NEG = {4'd0, 1'b1, 63'd0};

  // Parser state.
  jst_pkg::mode_t  mode_r, mode_nxt;
  logic [DW-1:0]   depth_r, depth_nxt;
  logic            is_key_r, is_key_nxt;
  logic            neg_r, neg_nxt;
  logic [63:0]     mag_r, mag_nxt;
  logic            ovf_r, ovf_nxt;
  logic [1:0]      hex_cnt_r, hex_cnt_nxt;
  logic [15:0]     hex_code_r, hex_code_nxt;
  logic            err_r, err_nxt;

  // Result queue: entry 0 is the head shown on the out port.
  jst_pkg::event_t q_r [3];
  jst_pkg::event_t q_nxt [3];
  logic [1:0]      cnt_r, cnt_nxt;

  logic            in_fire, pop, at_end;
  logic [7:0]      b;
  jst_pkg::event_t ev [2];
  logic [1:0]      n;
  logic            do_add, add_fresh;
  logic [4:0]      hv;
  logic [63:0]     add_base;
  logic [67:0]     add_sum, add_limit;
  logic [1:0]      cnt_after;

  // The queue always has room for the two results one beat can cause when it accepts.
  assign in_tready  = (cnt_r <= 2'd1);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign at_end     = in_tuser;
  assign b          = in_tdata;

  assign out_tdata  = {4'd0, q_r[0].code, q_r[0].int_value, q_r[0].data_byte};
  assign out_tuser  = q_r[0].kind;
  assign out_tlast  = q_r[0].last;

  // Parser step: the whole byte is decoded here, between the state registers and the queue.
  always_comb begin
    mode_nxt     = mode_r;
    depth_nxt    = depth_r;
    is_key_nxt   = is_key_r;
    neg_nxt      = neg_r;
    mag_nxt      = mag_r;
    ovf_nxt      = ovf_r;
    hex_cnt_nxt  = hex_cnt_r;
    hex_code_nxt = hex_code_r;
    err_nxt      = err_r;
    ev[0]        = jst_pkg::mk_ev(jst_pkg::EV_OPEN, 8'd0, 64'd0, jst_pkg::ERR_NONE_END);
    ev[1]        = ev[0];
    n            = 2'd0;
    do_add       = 1'b0;
    add_fresh    = 1'b0;
    hv           = jst_pkg::hex_val(b);
    add_base     = 64'd0;
    add_sum      = 68'd0;
    add_limit    = LIMIT_POS;

    if (in_fire && !err_r) begin
      // A number ends on the first byte that is not a digit or on the end marker; unless that
      // byte ends it in an error, it is then parsed in the position after the value.
      if (mode_r == jst_pkg::M_NDIG && (at_end || !jst_pkg::is_digit(b))) begin
        if (!at_end && (b == jst_pkg::CH_DOT || b == jst_pkg::CH_LOW_E ||
                        b == jst_pkg::CH_UP_E)) begin
          ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0, jst_pkg::ERR_FLOAT);
          n = n + 2'd1;
          err_nxt = 1'b1;
        end else if (ovf_r) begin
          ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0, jst_pkg::ERR_OVERFLOW);
          n = n + 2'd1;
          err_nxt = 1'b1;
        end else begin
          ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_INT, 8'd0,
                                    neg_r ? (64'd0 - mag_r) : mag_r,
                                    jst_pkg::ERR_NONE_END);
          n = n + 2'd1;
          mode_nxt = (depth_r != '0) ? jst_pkg::M_AFTER : jst_pkg::M_END;
        end
      end

      if (!err_nxt) begin
        if (at_end) begin
          if (mode_nxt == jst_pkg::M_END) begin
            ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_DONE, 8'd0, 64'd0, jst_pkg::ERR_NONE_END);
          end else begin
            ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0,
                                      jst_pkg::ERR_NONE_END);
            err_nxt = 1'b1;
          end
          n = n + 2'd1;
        end else begin
          unique case (mode_nxt)
            jst_pkg::M_TOP, jst_pkg::M_VALUE: begin
              if (!jst_pkg::is_ws(b)) begin
                if (b == jst_pkg::CH_LBRACE) begin
                  if (depth_r >= MAX_D) begin
                    ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0,
                                              jst_pkg::ERR_DEPTH);
                    err_nxt = 1'b1;
                  end else begin
                    depth_nxt = depth_r + DW'(1);
                    ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_OPEN, 8'd0, 64'd0,
                                              jst_pkg::ERR_NONE_END);
                    mode_nxt = jst_pkg::M_OBJ_FIRST;
                  end
                  n = n + 2'd1;
                end else if (b == jst_pkg::CH_QUOTE) begin
                  is_key_nxt = 1'b0;
                  mode_nxt   = jst_pkg::M_STR;
                end else if (b == jst_pkg::CH_MINUS) begin
                  neg_nxt  = 1'b1;
                  mag_nxt  = 64'd0;
                  ovf_nxt  = 1'b0;
                  mode_nxt = jst_pkg::M_NSIGN;
                end else if (jst_pkg::is_digit(b)) begin
                  neg_nxt   = 1'b0;
                  do_add    = 1'b1;
                  add_fresh = 1'b1;
                  mode_nxt  = jst_pkg::M_NDIG;
                end else begin
                  ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0,
                                            jst_pkg::ERR_BAD_VALUE);
                  n = n + 2'd1;
                  err_nxt = 1'b1;
                end
              end
            end
            jst_pkg::M_OBJ_FIRST: begin
              if (!jst_pkg::is_ws(b)) begin
                if (b == jst_pkg::CH_RBRACE) begin
                  ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_CLOSE, 8'd0, 64'd0,
                                            jst_pkg::ERR_NONE_END);
                  depth_nxt = depth_r - DW'(1);
                  mode_nxt = (depth_nxt != '0) ? jst_pkg::M_AFTER : jst_pkg::M_END;
                end else if (b == jst_pkg::CH_QUOTE) begin
                  is_key_nxt = 1'b1;
                  mode_nxt   = jst_pkg::M_STR;
                end else begin
                  ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0,
                                            jst_pkg::ERR_EXPECTED);
                  err_nxt = 1'b1;
                end
                if (b != jst_pkg::CH_QUOTE) n = n + 2'd1;
              end
            end
            jst_pkg::M_KEY_NEXT: begin
              if (!jst_pkg::is_ws(b)) begin
                if (b == jst_pkg::CH_QUOTE) begin
                  is_key_nxt = 1'b1;
                  mode_nxt   = jst_pkg::M_STR;
                end else begin
                  ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0,
                                            jst_pkg::ERR_EXPECTED);
                  n = n + 2'd1;
                  err_nxt = 1'b1;
                end
              end
            end
            jst_pkg::M_COLON: begin
              if (!jst_pkg::is_ws(b)) begin
                if (b == jst_pkg::CH_COLON) begin
                  mode_nxt = jst_pkg::M_VALUE;
                end else begin
                  ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0,
                                            jst_pkg::ERR_EXPECTED);
                  n = n + 2'd1;
                  err_nxt = 1'b1;
                end
              end
            end
            jst_pkg::M_AFTER: begin
              if (!jst_pkg::is_ws(b)) begin
                if (b == jst_pkg::CH_COMMA) begin
                  mode_nxt = jst_pkg::M_KEY_NEXT;
                end else if (b == jst_pkg::CH_RBRACE) begin
                  ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_CLOSE, 8'd0, 64'd0,
                                            jst_pkg::ERR_NONE_END);
                  n = n + 2'd1;
                  if (depth_r != '0) depth_nxt = depth_r - DW'(1);
                  mode_nxt = (depth_nxt != '0) ? jst_pkg::M_AFTER : jst_pkg::M_END;
                end else begin
                  ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0,
                                            jst_pkg::ERR_COMMA);
                  n = n + 2'd1;
                  err_nxt = 1'b1;
                end
              end
            end
            jst_pkg::M_STR: begin
              if (b == jst_pkg::CH_QUOTE) begin
                if (is_key_r) begin
                  ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_KEY_END, 8'd0, 64'd0,
                                            jst_pkg::ERR_NONE_END);
                  mode_nxt = jst_pkg::M_COLON;
                end else begin
                  ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_STR_END, 8'd0, 64'd0,
                                            jst_pkg::ERR_NONE_END);
                  mode_nxt = (depth_r != '0) ? jst_pkg::M_AFTER : jst_pkg::M_END;
                end
                n = n + 2'd1;
              end else if (b == jst_pkg::CH_BSLASH) begin
                mode_nxt = jst_pkg::M_ESC;
              end else begin
                ev[n[0]] = jst_pkg::mk_ev(is_key_r ? jst_pkg::EV_KEY_BYTE
                                                   : jst_pkg::EV_STR_BYTE,
                                          b, 64'd0, jst_pkg::ERR_NONE_END);
                n = n + 2'd1;
              end
            end
            jst_pkg::M_ESC: begin
              mode_nxt = jst_pkg::M_STR;
              // Simple escapes decode to one byte; reuse a single emit below.
              ev[n[0]] = jst_pkg::mk_ev(is_key_r ? jst_pkg::EV_KEY_BYTE
                                                 : jst_pkg::EV_STR_BYTE,
                                        b, 64'd0, jst_pkg::ERR_NONE_END);
              unique case (b)
                jst_pkg::CH_QUOTE, jst_pkg::CH_BSLASH, jst_pkg::CH_SLASH: begin
                  n = n + 2'd1;
                end
                jst_pkg::CH_LOW_N: begin
                  ev[n[0]].data_byte = 8'h0A;
                  n = n + 2'd1;
                end
                jst_pkg::CH_LOW_T: begin
                  ev[n[0]].data_byte = 8'h09;
                  n = n + 2'd1;
                end
                jst_pkg::CH_LOW_R: begin
                  ev[n[0]].data_byte = 8'h0D;
                  n = n + 2'd1;
                end
                jst_pkg::CH_LOW_B: begin
                  ev[n[0]].data_byte = 8'h08;
                  n = n + 2'd1;
                end
                jst_pkg::CH_LOW_F: begin
                  ev[n[0]].data_byte = 8'h0C;
                  n = n + 2'd1;
                end
                jst_pkg::CH_LOW_U: begin
                  hex_cnt_nxt  = 2'd0;
                  hex_code_nxt = 16'd0;
                  mode_nxt     = jst_pkg::M_HEX;
                end
                default: begin
                  ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0,
                                            jst_pkg::ERR_ESCAPE);
                  n = n + 2'd1;
                  err_nxt = 1'b1;
                end
              endcase
            end
            jst_pkg::M_HEX: begin
              if (hv[4]) begin
                ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0,
                                          jst_pkg::ERR_HEX);
                n = n + 2'd1;
                err_nxt = 1'b1;
              end else begin
                hex_code_nxt = {hex_code_r[11:0], hv[3:0]};
                if (hex_cnt_r == 2'd3) begin
                  hex_cnt_nxt = 2'd0;
                  mode_nxt    = jst_pkg::M_STR;
                  if (hex_code_nxt < 16'h0080) begin
                    ev[n[0]] = jst_pkg::mk_ev(is_key_r ? jst_pkg::EV_KEY_BYTE
                                                       : jst_pkg::EV_STR_BYTE,
                                              hex_code_nxt[7:0], 64'd0,
                                              jst_pkg::ERR_NONE_END);
                    n = n + 2'd1;
                  end else begin
                    // Two-byte form; the lead byte keeps only its low eight bits.
                    ev[0] = jst_pkg::mk_ev(is_key_r ? jst_pkg::EV_KEY_BYTE
                                                    : jst_pkg::EV_STR_BYTE,
                                           jst_pkg::UTF_LEAD | hex_code_nxt[13:6], 64'd0,
                                           jst_pkg::ERR_NONE_END);
                    ev[1] = jst_pkg::mk_ev(is_key_r ? jst_pkg::EV_KEY_BYTE
                                                    : jst_pkg::EV_STR_BYTE,
                                           jst_pkg::UTF_CONT | {2'b00, hex_code_nxt[5:0]},
                                           64'd0, jst_pkg::ERR_NONE_END);
                    n = 2'd2;
                  end
                end else begin
                  hex_cnt_nxt = hex_cnt_r + 2'd1;
                end
              end
            end
            jst_pkg::M_NSIGN: begin
              if (jst_pkg::is_digit(b)) begin
                do_add   = 1'b1;
                mode_nxt = jst_pkg::M_NDIG;
              end else begin
                ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0,
                                          jst_pkg::ERR_NUMBER);
                n = n + 2'd1;
                err_nxt = 1'b1;
              end
            end
            jst_pkg::M_NDIG: begin
              do_add = 1'b1;
            end
            default: begin
              // Complete value seen: only whitespace may follow.
              if (!jst_pkg::is_ws(b)) begin
                ev[n[0]] = jst_pkg::mk_ev(jst_pkg::EV_ERROR, 8'd0, 64'd0,
                                          jst_pkg::ERR_TRAILING);
                n = n + 2'd1;
                err_nxt = 1'b1;
              end
            end
          endcase
        end
      end
    end

    // Decimal accumulate, shared by every place a digit is taken: m*10+d is formed as
    // (m<<3)+(m<<1)+d and checked in 68 bits against the magnitude limit of the signed range.
    if (do_add) begin
      add_base  = add_fresh ? 64'd0 : mag_r;
      add_sum   = ({4'd0, add_base} << 3) + ({4'd0, add_base} << 1) +
                  {64'd0, b[3:0] - jst_pkg::CH_ZERO[3:0]};
      add_limit = neg_nxt ? LIMIT_NEG : LIMIT_POS;
      if ((ovf_r && !add_fresh) || (add_sum > add_limit)) begin
        ovf_nxt = 1'b1;
        mag_nxt = add_base;
      end else begin
        ovf_nxt = 1'b0;
        mag_nxt = add_sum[63:0];
      end
    end

    // End of text always restarts the parser, whatever came before.
    if (in_fire && at_end) begin
      mode_nxt     = jst_pkg::M_TOP;
      depth_nxt    = '0;
      is_key_nxt   = 1'b0;
      neg_nxt      = 1'b0;
      mag_nxt      = 64'd0;
      ovf_nxt      = 1'b0;
      hex_cnt_nxt  = 2'd0;
      hex_code_nxt = 16'd0;
      err_nxt      = 1'b0;
    end

    if (n == 2'd2) begin
      ev[1].last = 1'b1;
    end else if (n == 2'd1) begin
      ev[0].last = 1'b1;
    end
  end

  // Queue update: shift out the head on a pop, then append this beat's results behind it.
  always_comb begin
    cnt_after = cnt_r - {1'b0, pop};
    q_nxt[0]  = pop ? q_r[1] : q_r[0];
    q_nxt[1]  = pop ? q_r[2] : q_r[1];
    q_nxt[2]  = q_r[2];
    if (n != 2'd0) begin
      if (cnt_after == 2'd0) q_nxt[0] = ev[0];
      if (cnt_after == 2'd1) q_nxt[1] = ev[0];
      if (n == 2'd2) begin
        if (cnt_after == 2'd0) q_nxt[1] = ev[1];
        if (cnt_after == 2'd1) q_nxt[2] = ev[1];
      end
    end
    cnt_nxt = cnt_after + n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= jst_pkg::M_TOP;
      depth_r    <= '0;
      is_key_r   <= 1'b0;
      neg_r      <= 1'b0;
      mag_r      <= 64'd0;
      ovf_r      <= 1'b0;
      hex_cnt_r  <= 2'd0;
      hex_code_r <= 16'd0;
      err_r      <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      mode_r     <= mode_nxt;
      depth_r    <= depth_nxt;
      is_key_r   <= is_key_nxt;
      neg_r      <= neg_nxt;
      mag_r      <= mag_nxt;
      ovf_r      <= ovf_nxt;
      hex_cnt_r  <= hex_cnt_nxt;
      hex_code_r <= hex_code_nxt;
      err_r      <= err_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
    q_r[2] <= q_nxt[2];
  end

  // An end marker always leaves the parser in its start state.
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser) |=> (mode_r == jst_pkg::M_TOP && !err_r && depth_r == '0))
    else $error("end marker did not restart the parser");

  // Once an error is latched, text bytes produce no results.
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && err_r && !in_tuser) |=> (cnt_r == $past(cnt_r) - {1'b0, $past(pop)}))
    else $error("result queued after a latched error");

  // Open object count never passes the configured limit.
  a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= MAX_D)
    else $error("nesting depth above limit");

  // Whole runs are queued, so the newest queued result always closes its run.
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) || (cnt_r == 2'd1 && q_r[0].last) || (cnt_r == 2'd2 && q_r[1].last) ||
    (cnt_r == 2'd3 && q_r[2].last))
    else $error("queue tail is not the end of a run");

  // A partial unicode escape only exists inside the hex digit state.
  a_hex_in_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (hex_cnt_r != 2'd0) |-> (mode_r == jst_pkg::M_HEX))
    else $error("hex digit count outside unicode escape");

endmodule

[verif/json_subset_tokenizer_checker.sv]
// Scoreboard for the JSON subset tokenizer: watches both streams, tokenizes every accepted
// input beat on its own and compares each result beat against the oldest event still due.
// Depends on jst_pkg for the event, error and parser position types.
`timescale 1ns / 100ps

module json_subset_tokenizer_checker #(
  parameter int MAX_DEPTH = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          outstanding,
  output int          parsed_beats,
  output int          results_checked,
  output int          docs_done,
  output int          error_events
);

  // Tokenizer state as the block should hold it.
  jst_pkg::mode_t pmode;
  int             depth;
  logic           is_key;
  logic           neg;
  logic           ovf;
  logic [63:0]    mag;
  logic [1:0]     hex_cnt;
  logic [15:0]    hex_acc;
  logic           err_latched;

  jst_pkg::event_t events_due[$];
  jst_pkg::event_t beat_events[$];

  int mismatches;
  int parsed_cnt;
  int checked_cnt;
  int done_cnt;
  int err_cnt;

  function automatic logic ws_byte(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic dec_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  task automatic clear_parser();
    pmode       = jst_pkg::M_TOP;
    depth       = 0;
    is_key      = 1'b0;
    neg         = 1'b0;
    ovf         = 1'b0;
    mag         = 64'd0;
    hex_cnt     = 2'd0;
    hex_acc     = 16'd0;
    err_latched = 1'b0;
  endtask

  task automatic note_event(input jst_pkg::ev_kind_t k, input logic [7:0] d,
                            input logic [63:0] v, input jst_pkg::err_code_t c);
    jst_pkg::event_t e;
    e.kind      = k;
    e.data_byte = d;
    e.int_value = v;
    e.code      = c;
    e.last      = 1'b0;
    beat_events = {beat_events, e};
    if (k == jst_pkg::EV_DONE) done_cnt++;
  endtask

  task automatic raise_error(input jst_pkg::err_code_t c);
    note_event(jst_pkg::EV_ERROR, 8'h00, 64'd0, c);
    err_latched = 1'b1;
    err_cnt++;
  endtask

  task automatic text_byte(input logic [7:0] b);
    note_event(is_key ? jst_pkg::EV_KEY_BYTE : jst_pkg::EV_STR_BYTE, b, 64'd0,
               jst_pkg::ERR_NONE_END);
  endtask

  // A finished value leaves us inside an object or at the end of the document.
  task automatic close_value();
    pmode = (depth != 0) ? jst_pkg::M_AFTER : jst_pkg::M_END;
  endtask

  // Accumulate one digit, saturating into the overflow flag against the signed 64-bit range.
  task automatic push_digit(input logic [7:0] b);
    logic [63:0] d;
    logic [63:0] lim;
    d   = {56'd0, b - jst_pkg::CH_ZERO};
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (ovf || mag > (lim - d) / 64'd10) ovf = 1'b1;
    else mag = mag * 64'd10 + d;
  endtask

  task automatic begin_value(input logic [7:0] b);
    if (b == jst_pkg::CH_LBRACE) begin
      if (depth >= MAX_DEPTH) begin
        raise_error(jst_pkg::ERR_DEPTH);
      end else begin
        depth++;
        note_event(jst_pkg::EV_OPEN, 8'h00, 64'd0, jst_pkg::ERR_NONE_END);
        pmode = jst_pkg::M_OBJ_FIRST;
      end
    end else if (b == jst_pkg::CH_QUOTE) begin
      is_key = 1'b0;
      pmode  = jst_pkg::M_STR;
    end else if (b == jst_pkg::CH_MINUS) begin
      neg   = 1'b1;
      mag   = 64'd0;
      ovf   = 1'b0;
      pmode = jst_pkg::M_NSIGN;
    end else if (dec_digit(b)) begin
      neg   = 1'b0;
      mag   = 64'd0;
      ovf   = 1'b0;
      push_digit(b);
      pmode = jst_pkg::M_NDIG;
    end else begin
      raise_error(jst_pkg::ERR_BAD_VALUE);
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    int nib;
    case (pmode)
      jst_pkg::M_TOP, jst_pkg::M_VALUE: begin
        if (!ws_byte(b)) begin_value(b);
      end
      jst_pkg::M_OBJ_FIRST: begin
        if (!ws_byte(b)) begin
          if (b == jst_pkg::CH_RBRACE) begin
            note_event(jst_pkg::EV_CLOSE, 8'h00, 64'd0, jst_pkg::ERR_NONE_END);
            depth--;
            close_value();
          end else if (b == jst_pkg::CH_QUOTE) begin
            is_key = 1'b1;
            pmode  = jst_pkg::M_STR;
          end else begin
            raise_error(jst_pkg::ERR_EXPECTED);
          end
        end
      end
      jst_pkg::M_KEY_NEXT: begin
        if (!ws_byte(b)) begin
          if (b == jst_pkg::CH_QUOTE) begin
            is_key = 1'b1;
            pmode  = jst_pkg::M_STR;
          end else begin
            raise_error(jst_pkg::ERR_EXPECTED);
          end
        end
      end
      jst_pkg::M_COLON: begin
        if (!ws_byte(b)) begin
          if (b == jst_pkg::CH_COLON) pmode = jst_pkg::M_VALUE;
          else raise_error(jst_pkg::ERR_EXPECTED);
        end
      end
      jst_pkg::M_AFTER: begin
        if (!ws_byte(b)) begin
          if (b == jst_pkg::CH_COMMA) begin
            pmode = jst_pkg::M_KEY_NEXT;
          end else if (b == jst_pkg::CH_RBRACE) begin
            note_event(jst_pkg::EV_CLOSE, 8'h00, 64'd0, jst_pkg::ERR_NONE_END);
            if (depth != 0) depth--;
            close_value();
          end else begin
            raise_error(jst_pkg::ERR_COMMA);
          end
        end
      end
      jst_pkg::M_STR: begin
        if (b == jst_pkg::CH_QUOTE) begin
          if (is_key) begin
            note_event(jst_pkg::EV_KEY_END, 8'h00, 64'd0, jst_pkg::ERR_NONE_END);
            pmode = jst_pkg::M_COLON;
          end else begin
            note_event(jst_pkg::EV_STR_END, 8'h00, 64'd0, jst_pkg::ERR_NONE_END);
            close_value();
          end
        end else if (b == jst_pkg::CH_BSLASH) begin
          pmode = jst_pkg::M_ESC;
        end else begin
          text_byte(b);
        end
      end
      jst_pkg::M_ESC: begin
        pmode = jst_pkg::M_STR;
        case (b)
          jst_pkg::CH_QUOTE, jst_pkg::CH_BSLASH, jst_pkg::CH_SLASH: text_byte(b);
          jst_pkg::CH_LOW_N: text_byte(8'h0A);
          jst_pkg::CH_LOW_T: text_byte(8'h09);
          jst_pkg::CH_LOW_R: text_byte(8'h0D);
          jst_pkg::CH_LOW_B: text_byte(8'h08);
          jst_pkg::CH_LOW_F: text_byte(8'h0C);
          jst_pkg::CH_LOW_U: begin
            hex_cnt = 2'd0;
            hex_acc = 16'd0;
            pmode   = jst_pkg::M_HEX;
          end
          default: raise_error(jst_pkg::ERR_ESCAPE);
        endcase
      end
      jst_pkg::M_HEX: begin
        nib = hex_nibble(b);
        if (nib < 0) begin
          raise_error(jst_pkg::ERR_HEX);
        end else begin
          hex_acc = {hex_acc[11:0], nib[3:0]};
          if (hex_cnt == 2'd3) begin
            hex_cnt = 2'd0;
            pmode   = jst_pkg::M_STR;
            // Codes from 0x80 up split into a lead and a continuation byte; the lead
            // keeps only its low eight bits, so large codes lose their top bits.
            if (hex_acc < 16'h0080) begin
              text_byte(hex_acc[7:0]);
            end else begin
              text_byte(jst_pkg::UTF_LEAD | hex_acc[13:6]);
              text_byte(jst_pkg::UTF_CONT | {2'b00, hex_acc[5:0]});
            end
          end else begin
            hex_cnt++;
          end
        end
      end
      jst_pkg::M_NSIGN: begin
        if (dec_digit(b)) begin
          push_digit(b);
          pmode = jst_pkg::M_NDIG;
        end else begin
          raise_error(jst_pkg::ERR_NUMBER);
        end
      end
      jst_pkg::M_NDIG: push_digit(b);
      default: begin
        if (!ws_byte(b)) raise_error(jst_pkg::ERR_TRAILING);
      end
    endcase
  endtask

  // Work out every result one input beat causes and queue them in order.
  task automatic tokenize_beat(input logic eom, input logic [7:0] b);
    beat_events.delete();
    if (!err_latched) begin
      // A non-digit closes a pending integer before it is looked at in its own right.
      if (pmode == jst_pkg::M_NDIG && (eom || !dec_digit(b))) begin
        if (!eom && (b == jst_pkg::CH_DOT || b == jst_pkg::CH_LOW_E ||
                     b == jst_pkg::CH_UP_E)) begin
          raise_error(jst_pkg::ERR_FLOAT);
        end else if (ovf) begin
          raise_error(jst_pkg::ERR_OVERFLOW);
        end else begin
          note_event(jst_pkg::EV_INT, 8'h00, neg ? (64'd0 - mag) : mag,
                     jst_pkg::ERR_NONE_END);
          close_value();
        end
      end
      if (!err_latched) begin
        if (eom) begin
          if (pmode == jst_pkg::M_END) begin
            note_event(jst_pkg::EV_DONE, 8'h00, 64'd0, jst_pkg::ERR_NONE_END);
          end else begin
            raise_error(jst_pkg::ERR_NONE_END);
          end
        end else begin
          take_byte(b);
        end
      end
    end
    if (eom) clear_parser();
    if (beat_events.size() > 0) beat_events[beat_events.size() - 1].last = 1'b1;
    foreach (beat_events[i]) events_due = {events_due, beat_events[i]};
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    jst_pkg::event_t want;
    if (!rst_n) begin
      clear_parser();
      events_due.delete();
    end else begin
      // Results are compared before the input of the same edge is tokenized, since a
      // result never leaves in the cycle its beat is taken.
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        checked_cnt++;
        if (events_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, kind %0d, tdata %h",
                   $time, out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = events_due.pop_front();
          check_field("event_kind", 64'(want.kind), 64'(out_tuser));
          check_field("data_byte", 64'(want.data_byte), 64'(out_tdata[7:0]));
          check_field("int_value", want.int_value, out_tdata[71:8]);
          check_field("error_code", 64'(want.code), 64'(out_tdata[75:72]));
          check_field("tdata pad", 64'd0, 64'(out_tdata[79:76]));
          check_field("last_of_run", 64'(want.last), 64'(out_tlast));
        end
      end
      if (in_tvalid === 1'b1 && in_tready === 1'b1) begin
        if (!err_latched) parsed_cnt++;
        tokenize_beat(in_tuser, in_tdata);
      end
    end
    fail_count      <= mismatches;
    outstanding     <= events_due.size();
    parsed_beats    <= parsed_cnt;
    results_checked <= checked_cnt;
    docs_done       <= done_cnt;
    error_events    <= err_cnt;
  end

endmodule

[verif/json_subset_tokenizer_core_tb.sv]
// Top of the tokenizer testbench: clock, reset, byte stimulus and the final verdict.
// Depends on jst_pkg, json_subset_tokenizer_core and json_subset_tokenizer_checker.
`timescale 1ns / 100ps

module json_subset_tokenizer_core_tb;

  // A shallow nesting limit lets random documents run into the depth error now and then.
  localparam int NEST_LIMIT   = 5;
  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // data_in[7:0]
  logic        in_tuser = 1'b0;    // func: 1 marks end of text
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;          // data_byte, int_value, error_code, zero pad
  logic [3:0]  out_tuser;          // event_kind
  logic        out_tlast;

  int fail_count;
  int outstanding;
  int parsed_beats;
  int results_checked;
  int docs_done;
  int error_events;

  int idle_pct = 24;
  int stall_pct = 24;
  int beats_sent = 0;
  int doc_count = 0;
  int cycles = 0;

  // Bytes of the document being built; the end marker is added when it is sent.
  logic [7:0] doc_q[$];

  // Short hand-picked documents: every event kind, every escape and every error kind that
  // fits in a few bytes. The depth error is built separately since it follows NEST_LIMIT.
  string directed_docs[16] = '{
    "{\"k\":\"\\u00e9\\n\"}",
    " {\"a\":{},\"b\":-42}\t",
    "\"\\\"\\\\\\/\\t\\r\\b\\f\\uFFFF\"",
    "-12}",
    "17",
    "1.5",
    "-x",
    "\"\\q\"",
    "\"\\u1G\"",
    "{\"a\" 1}",
    "{\"a\":1 2}",
    "{\"a\":1,}",
    "x",
    "",
    "{\"a\":\"b\"} x",
    "3E2"
  };

  // Integers at and just past the signed 64-bit limits, plus leading-zero forms.
  string edge_numbers[9] = '{
    "9223372036854775807", "-9223372036854775808", "9223372036854775808",
    "-9223372036854775809", "18446744073709551616", "0", "-0", "000", "-00012"
  };

  // Bytes most likely to upset the parser when dropped into a valid document.
  string tricky_bytes = "{}\"\\:,.eE-ux0 ";
  string escape_letters = "\"\\/ntrbf";

  json_subset_tokenizer_core #(
    .MAX_DEPTH (NEST_LIMIT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  json_subset_tokenizer_checker #(
    .MAX_DEPTH (NEST_LIMIT)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .parsed_beats    (parsed_beats),
    .results_checked (results_checked),
    .docs_done       (docs_done),
    .error_events    (error_events)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The result side stalls at random; stall_pct drops to zero for the quiet stretch.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one beat and hold it until the block takes it. Random idle cycles go before the
  // beat; valid is left high after the accept so back-to-back beats need no second write.
  task automatic send_beat(input logic eom, input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eom;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    beats_sent++;
  endtask

  // Send the built document followed by an end marker carrying a random data byte.
  task automatic send_doc();
    foreach (doc_q[i]) send_beat(1'b0, doc_q[i]);
    send_beat(1'b1, 8'($urandom_range(0, 255)));
    doc_q.delete();
    doc_count++;
  endtask

  // Stop offering beats until every predicted result has been seen. The first edge lets
  // the checker's counters catch up with the beat taken at this edge.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Append one byte to the document under construction.
  task automatic put_byte(input logic [7:0] c);
    doc_q = {doc_q, c};
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // Optional run of whitespace: space or one of tab, LF, VT, FF, CR.
  task automatic put_ws();
    int n;
    int pick;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      pick = $urandom_range(0, 5);
      put_byte((pick == 0) ? 8'h20 : 8'(8 + pick));
    end
  endtask

  task automatic put_hex4(input logic [15:0] code);
    logic [3:0] nib;
    for (int i = 3; i >= 0; i--) begin
      nib = code[i*4 +: 4];
      if (nib < 10) put_byte(8'("0" + nib));
      else if ($urandom_range(0, 1) == 0) put_byte(8'("a" + nib - 10));
      else put_byte(8'("A" + nib - 10));
    end
  endtask

  // A quoted string of raw bytes (any value but quote and backslash) and escapes, with
  // unicode codes spread over the one-byte, two-byte and truncated ranges.
  task automatic put_string();
    int n;
    int sel;
    logic [7:0] c;
    logic [15:0] code;
    put_byte(jst_pkg::CH_QUOTE);
    n = $urandom_range(0, 5);
    repeat (n) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        c = 8'($urandom_range(0, 255));
        if (c == jst_pkg::CH_QUOTE || c == jst_pkg::CH_BSLASH) c = "_";
        put_byte(c);
      end else if (sel < 8) begin
        put_byte(jst_pkg::CH_BSLASH);
        put_byte(escape_letters[$urandom_range(0, escape_letters.len() - 1)]);
      end else begin
        put_byte(jst_pkg::CH_BSLASH);
        put_byte(jst_pkg::CH_LOW_U);
        case ($urandom_range(0, 3))
          0: code = 16'($urandom_range(0, 127));
          1: code = 16'($urandom_range(128, 16'h07FF));
          2: code = 16'($urandom_range(0, 65535));
          default: code = 16'hFFFF;
        endcase
        put_hex4(code);
      end
    end
    put_byte(jst_pkg::CH_QUOTE);
  endtask

  // Mostly short integers, with boundary values and long digit runs mixed in.
  task automatic put_number();
    case ($urandom_range(0, 9))
      0, 1: put_text(edge_numbers[$urandom_range(0, 8)]);
      2: begin
        if ($urandom_range(0, 1) == 0) put_byte(jst_pkg::CH_MINUS);
        repeat ($urandom_range(15, 21)) put_byte(8'("0" + $urandom_range(0, 9)));
      end
      default: begin
        if ($urandom_range(0, 2) == 0) put_byte(jst_pkg::CH_MINUS);
        repeat ($urandom_range(1, 4)) put_byte(8'("0" + $urandom_range(0, 9)));
      end
    endcase
  endtask

  task automatic put_scalar();
    if ($urandom_range(0, 1) == 0) put_string();
    else put_number();
  endtask

  // A well-formed document. Objects are built with an explicit stack of members still to
  // write per level; nesting past the limit is allowed only rarely.
  task automatic put_document();
    int open_left[$];
    bit need_comma[$];
    int lvl;
    put_ws();
    if ($urandom_range(0, 9) < 6) begin
      put_byte(jst_pkg::CH_LBRACE);
      open_left  = {open_left, int'($urandom_range(0, 3))};
      need_comma = {need_comma, 1'b0};
      while (open_left.size() > 0) begin
        lvl = open_left.size() - 1;
        put_ws();
        if (open_left[lvl] == 0) begin
          put_byte(jst_pkg::CH_RBRACE);
          void'(open_left.pop_back());
          void'(need_comma.pop_back());
        end else begin
          open_left[lvl] = open_left[lvl] - 1;
          if (need_comma[lvl]) begin
            put_byte(jst_pkg::CH_COMMA);
            put_ws();
          end
          need_comma[lvl] = 1'b1;
          put_string();
          put_ws();
          put_byte(jst_pkg::CH_COLON);
          put_ws();
          if ($urandom_range(0, 9) < 3 &&
              (open_left.size() < NEST_LIMIT || $urandom_range(0, 7) == 0)) begin
            put_byte(jst_pkg::CH_LBRACE);
            open_left  = {open_left, int'($urandom_range(0, 2))};
            need_comma = {need_comma, 1'b0};
          end else begin
            put_scalar();
          end
        end
      end
    end else begin
      put_scalar();
    end
    put_ws();
  endtask

  initial begin
    int base;
    int kind;
    int pos;
    int rounds;

    // Reset is held once, at the start of the run.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed documents first, then one that nests a level deeper than allowed.
    foreach (directed_docs[i]) begin
      put_text(directed_docs[i]);
      send_doc();
    end
    repeat (NEST_LIMIT + 1) put_byte(jst_pkg::CH_LBRACE);
    send_doc();
    drain_results();

    // Random part: mostly valid documents with random content, mixed with damaged documents
    // (overwritten, cut short, with a stray byte or trailing data) and raw noise. Every
    // beat sent counts toward the total, so the whole run stays near a thousand beats.
    base = beats_sent;
    rounds = 0;
    while (beats_sent - base < RANDOM_ITEMS) begin
      // A stretch of documents with neither side idling.
      if (rounds >= 10 && rounds < 30) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 24;
        stall_pct = 24;
      end
      kind = $urandom_range(0, 99);
      if (kind < 90) begin
        put_document();
        if (kind >= 70) begin
          pos = (doc_q.size() == 0) ? 0 : $urandom_range(0, doc_q.size() - 1);
          case ($urandom_range(0, 3))
            0: if (doc_q.size() > 0) doc_q[pos] = 8'($urandom_range(0, 255));
            1: while (doc_q.size() > pos) void'(doc_q.pop_back());
            2: doc_q.insert(pos, tricky_bytes[$urandom_range(0, tricky_bytes.len() - 1)]);
            default: put_byte(tricky_bytes[$urandom_range(0, 8)]);
          endcase
        end
        send_doc();
      end else begin
        // Noise: random bytes with the odd end marker in the middle.
        repeat ($urandom_range(1, 12))
          send_beat($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
        send_beat(1'b1, 8'($urandom_range(0, 255)));
        doc_count++;
      end
      if (rounds % 60 == 59) drain_results();
      rounds++;
    end

    // Let every predicted result arrive, then a short tail for stray beats.
    drain_results();
    repeat (8) @(posedge clk);

    $display("Summary: %0d input beats in %0d documents, %0d beats parsed, %0d results compared.",
             beats_sent, doc_count, parsed_beats, results_checked);
    $display("Summary: %0d documents completed cleanly, %0d error events, %0d mismatches.",
             docs_done, error_events, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/jst_pkg.sv
src/json_subset_tokenizer_core.sv
verif/json_subset_tokenizer_checker.sv
verif/json_subset_tokenizer_core_tb.sv
